### design/fpv_pkg.sv
// ----------------------------------------------------------------------------
// fpv_pkg: shared types and constants for the viewport fit block
// Word layouts of both channels, fixed-point widths, register indexes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package fpv_pkg;

    localparam int COORD_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int SCREEN_BITS    = 13;
    localparam int SCALE_SHIFT    = 48;
    localparam int SCALE_W        = SCREEN_BITS + SCALE_SHIFT;
    localparam int PROD_SHIFT     = 33;
    localparam int DIGIT_W        = 16;
    localparam int MUL_DIGITS     = (SCALE_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MUL_B_W        = MUL_DIGITS * DIGIT_W;
    localparam int PROD_W         = COORD_BITS + SCALE_W;
    localparam int INDEX_W        = 6;
    localparam int MAX_POINTS_DEF = 64;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0]   REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]   REG_SCREEN_HEIGHT = CFG_IDX_W'(1);
    localparam logic [SCREEN_BITS-1:0] SCREEN_RESET      = SCREEN_BITS'(450);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x_coord;
        coord_t y_coord;
        logic   last_point;
    } point_in_t;

    typedef struct packed {
        coord_t              fit_x;
        coord_t              fit_y;
        logic [INDEX_W-1:0]  point_index;
        logic                last_out;
        logic                overflow;
    } fit_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EXTENT,
        ST_CMP_START,
        ST_CMP_WAIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_READ,
        ST_FIT_START,
        ST_FIT_WAIT,
        ST_OUT
    } fit_state_t;

endpackage

### design/fpv_point_mem.sv
// ----------------------------------------------------------------------------
// fpv_point_mem: point store
// One write port and one registered read port, each entry an (x, y) pair.
// ----------------------------------------------------------------------------
module fpv_point_mem #(
    parameter int DEPTH = fpv_pkg::MAX_POINTS_DEF
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]          wr_addr,
    input  logic [2*fpv_pkg::COORD_BITS-1:0]  wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [2*fpv_pkg::COORD_BITS-1:0]  rd_data
);
    import fpv_pkg::*;

    logic [2*COORD_BITS-1:0] store [DEPTH];
    logic [2*COORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= store[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/fpv_mul.sv
// ----------------------------------------------------------------------------
// fpv_mul: shared digit-serial multiplier
// Multiplies a coordinate-wide operand by a scale-wide operand, one 16-bit
// digit of the scale operand per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module fpv_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fpv_pkg::COORD_BITS-1:0] op_a,
    input  logic [fpv_pkg::SCALE_W-1:0]   op_b,
    output logic                          done,
    output logic [fpv_pkg::PROD_W-1:0]    product
);
    import fpv_pkg::*;

    localparam int ACC_W = COORD_BITS + MUL_B_W;
    localparam int CNT_W = $clog2(MUL_DIGITS + 1);

    logic [COORD_BITS-1:0]         a_reg, a_next;
    logic [MUL_B_W-1:0]            b_reg, b_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [COORD_BITS+DIGIT_W-1:0] partial;

    always_comb begin
        partial   = a_reg * b_reg[MUL_B_W-1 -: DIGIT_W];
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            a_next   = op_a;
            b_next   = MUL_B_W'(op_b);
            acc_next = '0;
            cnt_next = CNT_W'(MUL_DIGITS);
        end else if (cnt_reg != '0) begin
            // shift the running sum one digit up, add the next partial product
            acc_next  = (acc_reg << DIGIT_W) + ACC_W'(partial);
            b_next    = b_reg << DIGIT_W;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[PROD_W-1:0];

endmodule

### design/fpv_div.sv
// ----------------------------------------------------------------------------
// fpv_div: scale divider
// Restoring division of (screen << 48) by a box extent, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module fpv_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [fpv_pkg::SCREEN_BITS-1:0] screen,
    input  logic [fpv_pkg::COORD_BITS-1:0]  divisor,
    output logic                            done,
    output logic [fpv_pkg::SCALE_W-1:0]     quotient
);
    import fpv_pkg::*;

    localparam int CNT_W = $clog2(SCALE_W + 1);

    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [COORD_BITS-1:0] d_reg, d_next;
    logic [SCALE_W-1:0]    qn_reg, qn_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [COORD_BITS:0]   rem_sh;
    logic [COORD_BITS:0]   diff;
    logic                  fits;

    always_comb begin
        rem_sh    = {rem_reg, qn_reg[SCALE_W-1]};
        diff      = rem_sh - {1'b0, d_reg};
        fits      = rem_sh >= {1'b0, d_reg};
        rem_next  = rem_reg;
        d_next    = d_reg;
        qn_next   = qn_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            d_next   = divisor;
            qn_next  = {screen, SCALE_SHIFT'(0)};
            cnt_next = CNT_W'(SCALE_W);
        end else if (cnt_reg != '0) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            rem_next  = fits ? diff[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
            qn_next   = {qn_reg[SCALE_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        qn_reg  <= qn_next;
    end

    assign done     = done_reg;
    assign quotient = qn_reg;

endmodule

### design/fit_points_to_viewport.sv
// ----------------------------------------------------------------------------
// fit_points_to_viewport: fit a 2D point set to a viewport with one scale
// Loads points, tracks their bounding box, then emits every point scaled by
// min(width/xsize, height/ysize) about the box center, offset to mid-screen.
//
// Usage:
//   s_ channel: one (x, y) Q16.16 point per word; last_point closes the set.
//   m_ channel: one fitted point per stored point, in load order, with its
//   index, last_out on the final word and overflow if points were dropped.
//   Points beyond MAX_POINTS are dropped and do not touch the box.
//   cfg_we/cfg_index/cfg_wdata: screen_width (0) and screen_height (1),
//   written while the block is idle; both reset to 450.
//   Loading accepts one point per cycle (s_ready stays high).
//   After the last point: an extent step, the axis compare (two passes of
//   the shared multiplier), the 61-bit scale division (skipped for a flat
//   box), then per point: one store read, two multiplies and one output
//   word. The multiplier works on 16-bit digits; the divider yields one
//   quotient bit per cycle.
//   A stalled m_ready holds the current word and the sequencer; s_ready is
//   low from the last point until the final word is taken.
//   Reset (aresetn low, synchronous) empties the set and restores the screen registers.
// ----------------------------------------------------------------------------
module fit_points_to_viewport #(
    parameter int MAX_POINTS = fpv_pkg::MAX_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [fpv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fpv_pkg::SCREEN_BITS-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fpv_pkg::point_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fpv_pkg::fit_out_t               m_data
);
    import fpv_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CW     = COORD_BITS;
    localparam int CMP_W  = SCREEN_BITS + COORD_BITS;
    localparam int D2_W   = COORD_BITS + 2;
    localparam int M_W    = PROD_W - PROD_SHIFT;
    localparam int HALF_W = SCREEN_BITS + FRAC_BITS - 1;
    localparam int R_W    = M_W + 2;
    localparam logic signed [R_W-1:0] R_MAX = {{(R_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [R_W-1:0] R_MIN = {{(R_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    fit_state_t             state_reg, state_next;
    logic [SCREEN_BITS-1:0] sw_reg, sw_next;
    logic [SCREEN_BITS-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    coord_t                 min_x_reg, min_x_next, max_x_reg, max_x_next;
    coord_t                 min_y_reg, min_y_next, max_y_reg, max_y_next;
    logic [CW-1:0]          xs_reg, xs_next, ys_reg, ys_next;
    logic                   cmp_sel_reg, cmp_sel_next;
    logic [CMP_W-1:0]       prod_a_reg, prod_a_next;
    logic                   use_x_reg, use_x_next;
    logic [SCALE_W-1:0]     c_reg, c_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic                   axis_reg, axis_next;
    logic                   neg_reg, neg_next;
    coord_t                 fit_x_reg, fit_x_next, fit_y_reg, fit_y_next;

    logic                   s_acc, m_acc, room, last_idx;
    logic                   xs_nz, ys_nz, pick_x, pick_y;
    logic [CW:0]            ext_x, ext_y;
    logic                   mul_start, mul_done;
    logic [CW-1:0]          mul_a;
    logic [SCALE_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_product;
    logic                   div_start, div_done;
    logic [SCALE_W-1:0]     div_q;
    logic                   mem_we, mem_re;
    logic [2*CW-1:0]        mem_rdata;
    coord_t                 rd_x, rd_y, p_sel, lo_sel, hi_sel;
    logic signed [D2_W-1:0] p_ext, lo_ext, hi_ext, d2, d2_mag;
    logic [CW-1:0]          mag;
    logic [M_W-1:0]         m_val;
    logic [HALF_W-1:0]      half;
    logic signed [R_W-1:0]  r_val;
    coord_t                 fit_val;

    fpv_point_mem #(
        .DEPTH(MAX_POINTS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({s_data.x_coord, s_data.y_coord}),
        .rd_en   (mem_re),
        .rd_addr (idx_reg),
        .rd_data (mem_rdata)
    );

    fpv_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    fpv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .screen   (use_x_reg ? sw_reg : sh_reg),
        .divisor  (use_x_reg ? xs_reg : ys_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Shared decode and fit arithmetic
    always_comb begin
        s_acc    = s_valid && s_ready;
        m_acc    = m_valid && m_ready;
        room     = count_reg < CNT_W'(MAX_POINTS);
        last_idx = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
        ext_x    = {max_x_reg[CW-1], max_x_reg} - {min_x_reg[CW-1], min_x_reg};
        ext_y    = {max_y_reg[CW-1], max_y_reg} - {min_y_reg[CW-1], min_y_reg};
        xs_nz    = xs_reg != '0;
        ys_nz    = ys_reg != '0;
        // the x axis wins when width*ysize < height*xsize
        pick_x   = xs_nz && (!ys_nz || (prod_a_reg < mul_product[CMP_W-1:0]));
        pick_y   = !pick_x && ys_nz;

        rd_x   = mem_rdata[2*CW-1:CW];
        rd_y   = mem_rdata[CW-1:0];
        p_sel  = axis_reg ? rd_y : rd_x;
        lo_sel = axis_reg ? min_y_reg : min_x_reg;
        hi_sel = axis_reg ? max_y_reg : max_x_reg;
        p_ext  = D2_W'(p_sel);
        lo_ext = D2_W'(lo_sel);
        hi_ext = D2_W'(hi_sel);
        // twice the offset from the box center, exact
        d2     = (p_ext <<< 1) - lo_ext - hi_ext;
        d2_mag = d2[D2_W-1] ? -d2 : d2;
        mag    = d2_mag[CW-1:0];

        m_val  = mul_product[PROD_W-1:PROD_SHIFT];
        half   = {(axis_reg ? sh_reg : sw_reg), (FRAC_BITS-1)'(0)};
        r_val  = neg_reg ? (R_W'(half) - R_W'(m_val)) : (R_W'(half) + R_W'(m_val));
        if (r_val > R_MAX) begin
            fit_val = coord_t'(R_MAX[CW-1:0]);
        end else if (r_val < R_MIN) begin
            fit_val = coord_t'(R_MIN[CW-1:0]);
        end else begin
            fit_val = coord_t'(r_val[CW-1:0]);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_acc && s_data.last_point) begin
                    state_next = ST_EXTENT;
                end
            end
            ST_EXTENT: begin
                state_next = ST_CMP_START;
            end
            ST_CMP_START: begin
                state_next = ST_CMP_WAIT;
            end
            ST_CMP_WAIT: begin
                if (mul_done) begin
                    if (!cmp_sel_reg) begin
                        state_next = ST_CMP_START;
                    end else if (pick_x || pick_y) begin
                        state_next = ST_DIV_START;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_FIT_START;
            end
            ST_FIT_START: begin
                state_next = ST_FIT_WAIT;
            end
            ST_FIT_WAIT: begin
                if (mul_done) begin
                    state_next = axis_reg ? ST_OUT : ST_FIT_START;
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    state_next = last_idx ? ST_LOAD : ST_READ;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and unit controls
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        mem_re    = 1'b0;
        mul_a     = cmp_sel_reg ? xs_reg : ys_reg;
        mul_b     = SCALE_W'(cmp_sel_reg ? sh_reg : sw_reg);
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
            end
            ST_CMP_START: begin
                mul_start = 1'b1;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_FIT_START: begin
                mul_start = 1'b1;
                mul_a     = mag;
                mul_b     = c_reg;
            end
            ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        mem_we = s_acc && room;

        m_data.fit_x       = fit_x_reg;
        m_data.fit_y       = fit_y_reg;
        m_data.point_index = INDEX_W'(idx_reg);
        m_data.last_out    = last_idx;
        m_data.overflow    = ovf_reg;
    end

    // Datapath and counters
    always_comb begin
        sw_next      = sw_reg;
        sh_next      = sh_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        min_x_next   = min_x_reg;
        max_x_next   = max_x_reg;
        min_y_next   = min_y_reg;
        max_y_next   = max_y_reg;
        xs_next      = xs_reg;
        ys_next      = ys_reg;
        cmp_sel_next = cmp_sel_reg;
        prod_a_next  = prod_a_reg;
        use_x_next   = use_x_reg;
        c_next       = c_reg;
        idx_next     = idx_reg;
        axis_next    = axis_reg;
        neg_next     = neg_reg;
        fit_x_next   = fit_x_reg;
        fit_y_next   = fit_y_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  sw_next = cfg_wdata;
                REG_SCREEN_HEIGHT: sh_next = cfg_wdata;
                default: begin
                    sw_next = sw_reg;
                end
            endcase
        end

        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (room) begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == '0) begin
                            min_x_next = s_data.x_coord;
                            max_x_next = s_data.x_coord;
                            min_y_next = s_data.y_coord;
                            max_y_next = s_data.y_coord;
                        end else begin
                            if (s_data.x_coord > max_x_reg) max_x_next = s_data.x_coord;
                            if (s_data.x_coord < min_x_reg) min_x_next = s_data.x_coord;
                            if (s_data.y_coord > max_y_reg) max_y_next = s_data.y_coord;
                            if (s_data.y_coord < min_y_reg) min_y_next = s_data.y_coord;
                        end
                    end else begin
                        // drop the point, flag the set
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_EXTENT: begin
                xs_next      = ext_x[CW-1:0];
                ys_next      = ext_y[CW-1:0];
                cmp_sel_next = 1'b0;
            end
            ST_CMP_WAIT: begin
                if (mul_done) begin
                    if (!cmp_sel_reg) begin
                        prod_a_next  = mul_product[CMP_W-1:0];
                        cmp_sel_next = 1'b1;
                    end else begin
                        use_x_next = pick_x;
                        idx_next   = '0;
                        if (!pick_x && !pick_y) begin
                            // flat box: everything lands on screen center
                            c_next = '0;
                        end
                    end
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    c_next = div_q;
                end
            end
            ST_READ: begin
                axis_next = 1'b0;
            end
            ST_FIT_START: begin
                neg_next = d2[D2_W-1];
            end
            ST_FIT_WAIT: begin
                if (mul_done) begin
                    axis_next = 1'b1;
                    if (axis_reg) begin
                        fit_y_next = fit_val;
                    end else begin
                        fit_x_next = fit_val;
                    end
                end
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (last_idx) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
            end
            default: begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sw_reg    <= SCREEN_RESET;
            sh_reg    <= SCREEN_RESET;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sw_reg    <= sw_next;
            sh_reg    <= sh_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_x_reg   <= min_x_next;
        max_x_reg   <= max_x_next;
        min_y_reg   <= min_y_next;
        max_y_reg   <= max_y_next;
        xs_reg      <= xs_next;
        ys_reg      <= ys_next;
        cmp_sel_reg <= cmp_sel_next;
        prod_a_reg  <= prod_a_next;
        use_x_reg   <= use_x_next;
        c_reg       <= c_next;
        idx_reg     <= idx_next;
        axis_reg    <= axis_next;
        neg_reg     <= neg_next;
        fit_x_reg   <= fit_x_next;
        fit_y_reg   <= fit_y_next;
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and output sides active together");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_out) |=> (s_ready && count_reg == '0))
        else $error("set not cleared after final word");

    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_CMP_WAIT || state_reg == ST_FIT_WAIT))
        else $error("multiplier finished outside a wait state");

endmodule
